// ===== rtl/tcpq_pkg.sv =====
// ---------------------------------------------------------------------------
// Two-class priority queue package
// Shared request and result types, operation and status codes, cell controls.
// ---------------------------------------------------------------------------
package tcpq_pkg;

	localparam int KEY_W = 16;
	localparam int AGE_W = 8;
	localparam int CNT_OUT_W = 5;

	localparam logic [1:0] FN_INSERT = 2'd0;
	localparam logic [1:0] FN_SERVE  = 2'd1;
	localparam logic [1:0] FN_CANCEL = 2'd2;
	localparam logic [1:0] FN_LOOKUP = 2'd3;

	localparam logic [1:0] STAT_DONE  = 2'd0;
	localparam logic [1:0] STAT_MISS  = 2'd1;
	localparam logic [1:0] STAT_EMPTY = 2'd2;
	localparam logic [1:0] STAT_FULL  = 2'd3;

	localparam logic [AGE_W-1:0] PREF_AGE_RESET = 8'd60;

	typedef struct packed {
		logic [1:0]       func;
		logic [KEY_W-1:0] id;
		logic [AGE_W-1:0] age;
	} in_t;

	typedef struct packed {
		logic [1:0]           status;
		logic [KEY_W-1:0]     served_id;
		logic [AGE_W-1:0]     found_age;
		logic [CNT_OUT_W-1:0] count;
	} out_t;

	// One slot of the queue as seen by its neighbors.
	typedef struct packed {
		logic             valid;
		logic [KEY_W-1:0] key;
		logic [AGE_W-1:0] age;
	} entry_t;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_FROM_PREV,
		OP_FROM_NEXT,
		OP_LOAD
	} cell_op_t;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

endpackage

// ===== rtl/two_class_priority_queue.sv =====
// ---------------------------------------------------------------------------
// Two-class priority queue with cancel by key
// An accepted request moves the queue from S_IDLE to S_EXEC, and its result
// is registered in S_EXEC once the result side is free. A new request is
// taken only back in S_IDLE, after the key compare in every cell and the
// shift of the cell chain for the previous one. Reset empties the queue and
// sets preferred_age to 60; payload is not reset.
// ---------------------------------------------------------------------------
module two_class_priority_queue #(
	parameter int CAPACITY = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  tcpq_pkg::in_t                 in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output tcpq_pkg::out_t                out_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [tcpq_pkg::AGE_W-1:0]    cfg_data
);
	import tcpq_pkg::*;

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam logic [CNT_W-1:0] CAP = CNT_W'(CAPACITY);

	state_t           state_q, state_d;
	in_t              req_q;
	out_t             out_q, out_d;
	logic             out_valid_q;
	logic [AGE_W-1:0] pref_age_q;
	logic [CNT_W-1:0] occ_q, occ_d;
	logic [CNT_W-1:0] pref_q, pref_d;

	entry_t           entries [CAPACITY];
	entry_t           prevs   [CAPACITY];
	entry_t           nexts   [CAPACITY];
	cell_op_t         ops     [CAPACITY];
	logic [CAPACITY-1:0] hits;
	logic [CAPACITY-1:0] valids;
	entry_t           new_entry;
	logic             accept;
	logic             exec_go;

	assign accept    = in_valid && in_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign exec_go   = (state_q == S_EXEC) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign cfg_ready = 1'b1;
	assign new_entry = '{valid: 1'b1, key: req_q.id, age: req_q.age};

	genvar g;
	generate
		for (g = 0; g < CAPACITY; g++) begin : g_cell
			if (g == 0) begin : g_head
				assign prevs[g] = '0;
			end else begin : g_mid
				assign prevs[g] = entries[g-1];
			end
			if (g == CAPACITY - 1) begin : g_tail
				assign nexts[g] = '0;
			end else begin : g_body
				assign nexts[g] = entries[g+1];
			end
			assign valids[g] = entries[g].valid;

			tcpq_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.op         (ops[g]),
				.new_entry  (new_entry),
				.prev_entry (prevs[g]),
				.next_entry (nexts[g]),
				.cmp_en     (accept),
				.cmp_id     (in_data.id),
				.entry      (entries[g]),
				.hit        (hits[g])
			);
		end
	endgenerate

	// Decide the operation from the registered hit vector and drive the chain.
	always_comb begin
		logic             any_hit;
		logic [IDX_W-1:0] hit_pos;
		logic [IDX_W-1:0] pos;
		logic [AGE_W-1:0] hit_age;
		logic             do_insert;
		logic             do_remove;
		logic             is_pref;

		any_hit   = |hits;
		hit_pos   = '0;
		hit_age   = '0;
		pos       = '0;
		do_insert = 1'b0;
		do_remove = 1'b0;
		is_pref   = req_q.age >= pref_age_q;
		for (int i = 0; i < CAPACITY; i++) begin
			if (hits[i]) begin
				hit_pos = hit_pos | IDX_W'(i);
				hit_age = hit_age | entries[i].age;
			end
		end

		state_d          = state_q;
		occ_d            = occ_q;
		pref_d           = pref_q;
		out_d            = out_q;
		out_d.status     = STAT_DONE;
		out_d.served_id  = '0;
		out_d.found_age  = '0;

		case (req_q.func)
			FN_INSERT: begin
				if (any_hit) begin
					out_d.status = STAT_MISS;
				end else if (occ_q >= CAP) begin
					out_d.status = STAT_FULL;
				end else begin
					do_insert = 1'b1;
					pos = is_pref ? IDX_W'(pref_q) : IDX_W'(occ_q);
				end
			end
			FN_SERVE: begin
				if (occ_q == '0) begin
					out_d.status = STAT_EMPTY;
				end else begin
					do_remove       = 1'b1;
					out_d.served_id = entries[0].key;
				end
			end
			FN_CANCEL: begin
				if (!any_hit) begin
					out_d.status = STAT_MISS;
				end else begin
					do_remove = 1'b1;
					pos       = hit_pos;
				end
			end
			default: begin
				if (!any_hit) begin
					out_d.status = STAT_MISS;
				end else begin
					out_d.found_age = hit_age;
				end
			end
		endcase

		for (int i = 0; i < CAPACITY; i++) begin
			ops[i] = OP_HOLD;
			if (exec_go && do_insert) begin
				if (IDX_W'(i) == pos) begin
					ops[i] = OP_LOAD;
				end else if (IDX_W'(i) > pos) begin
					ops[i] = OP_FROM_PREV;
				end
			end else if (exec_go && do_remove) begin
				if (IDX_W'(i) >= pos) begin
					ops[i] = OP_FROM_NEXT;
				end
			end
		end

		if (do_insert) begin
			occ_d = occ_q + 1'b1;
			if (is_pref) begin
				pref_d = pref_q + 1'b1;
			end
		end else if (do_remove) begin
			occ_d = occ_q - 1'b1;
			if (CNT_W'(pos) < pref_q) begin
				pref_d = pref_q - 1'b1;
			end
		end
		out_d.count = CNT_OUT_W'(occ_d);

		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (exec_go) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			occ_q       <= '0;
			pref_q      <= '0;
			pref_age_q  <= PREF_AGE_RESET;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				pref_age_q <= cfg_data;
			end
			if (exec_go) begin
				out_valid_q <= 1'b1;
				occ_q       <= occ_d;
				pref_q      <= pref_d;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= in_data;
		end
		if (exec_go) begin
			out_q <= out_d;
		end
	end

`ifndef ASSERT_OFF
	// The preferred class is always a prefix of the held entries.
	a_pref_le_occ: assert property (@(posedge clk) disable iff (!arst_n)
		pref_q <= occ_q)
		else $error("preferred count exceeds occupancy");

	// Occupied cells form a contiguous run from the head of length occupancy.
	a_valid_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valids) == 32'(occ_q))
		else $error("cell valid bits disagree with occupancy");

	// Keys are unique, so a compare never hits more than one cell.
	a_hit_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC) |-> $onehot0(hits))
		else $error("key matched in more than one cell");

	// Every accepted request produces a result when the chain executes.
	a_exec_result: assert property (@(posedge clk) disable iff (!arst_n)
		exec_go |=> out_valid)
		else $error("executed request produced no result");
`endif

endmodule

// ===== rtl/tcpq_cell.sv =====
// ---------------------------------------------------------------------------
// Queue cell
// Holds one slot, compares its key against a request, and shifts toward
// either neighbor or loads a new entry when told to.
// ---------------------------------------------------------------------------
module tcpq_cell (
	input  logic                     clk,
	input  logic                     arst_n,
	input  tcpq_pkg::cell_op_t       op,
	input  tcpq_pkg::entry_t         new_entry,
	input  tcpq_pkg::entry_t         prev_entry,
	input  tcpq_pkg::entry_t         next_entry,
	input  logic                     cmp_en,
	input  logic [tcpq_pkg::KEY_W-1:0] cmp_id,
	output tcpq_pkg::entry_t         entry,
	output logic                     hit
);
	import tcpq_pkg::*;

	logic             valid_q;
	logic [KEY_W-1:0] key_q;
	logic [AGE_W-1:0] age_q;
	logic             hit_q;
	entry_t           src;

	always_comb begin
		case (op)
			OP_FROM_PREV: src = prev_entry;
			OP_FROM_NEXT: src = next_entry;
			OP_LOAD:      src = new_entry;
			default:      src = entry;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			hit_q   <= 1'b0;
		end else begin
			valid_q <= src.valid;
			if (cmp_en) begin
				hit_q <= valid_q && (key_q == cmp_id);
			end
		end
	end

	always_ff @(posedge clk) begin
		key_q <= src.key;
		age_q <= src.age;
	end

	assign entry = '{valid: valid_q, key: key_q, age: age_q};
	assign hit   = hit_q;

endmodule

// ===== bench/tcpq_order_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Two-class priority queue checker
// Watches the request, result and setting channels, keeps its own copy of the
// queue order, predicts the result of every accepted request and compares each
// accepted result field by field with the oldest prediction still waiting.
// ---------------------------------------------------------------------------
module tcpq_order_checker #(
	parameter int CAPACITY = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_ready,
	input  tcpq_pkg::in_t              in_data,
	input  logic                       out_valid,
	input  logic                       out_ready,
	input  tcpq_pkg::out_t             out_data,
	input  logic                       cfg_valid,
	input  logic                       cfg_ready,
	input  logic [tcpq_pkg::AGE_W-1:0] cfg_data,
	output int                         fails,
	output int                         pending
);
	import tcpq_pkg::*;

	logic [KEY_W-1:0] slot_keys [CAPACITY];
	logic [AGE_W-1:0] slot_ages [CAPACITY];
	int               held = 0;
	int               n_pref = 0;
	logic [AGE_W-1:0] pref_age = PREF_AGE_RESET;
	out_t             predicted_replies [$];
	int               mismatch_total = 0;

	task automatic report(input string msg);
		$display("%0t ns  mismatch: %s", $time, msg);
		mismatch_total++;
	endtask

	function automatic int find_slot(input logic [KEY_W-1:0] key);
		int i;
		for (i = 0; i < held; i++)
			if (slot_keys[i] == key)
				return i;
		return -1;
	endfunction

	function automatic void drop_slot(input int pos);
		int i;
		for (i = pos; i < held - 1; i++) begin
			slot_keys[i] = slot_keys[i + 1];
			slot_ages[i] = slot_ages[i + 1];
		end
		held--;
		if (pos < n_pref)
			n_pref--;
	endfunction

	function automatic void put_slot(input int pos, input logic [KEY_W-1:0] key,
			input logic [AGE_W-1:0] age);
		int i;
		for (i = held; i > pos; i--) begin
			slot_keys[i] = slot_keys[i - 1];
			slot_ages[i] = slot_ages[i - 1];
		end
		slot_keys[pos] = key;
		slot_ages[pos] = age;
		held++;
	endfunction

	// Applies one request to the shadow queue and returns the result it must give.
	function automatic out_t queue_op_result(input in_t req);
		out_t res;
		int   pos;
		res = '0;
		res.status = STAT_DONE;
		pos = find_slot(req.id);
		case (req.func)
		FN_INSERT: begin
			// The duplicate check wins over the full check.
			if (pos >= 0)
				res.status = STAT_MISS;
			else if (held >= CAPACITY)
				res.status = STAT_FULL;
			else if (req.age >= pref_age) begin
				put_slot(n_pref, req.id, req.age);
				n_pref++;
			end else
				put_slot(held, req.id, req.age);
		end
		FN_SERVE: begin
			if (held == 0)
				res.status = STAT_EMPTY;
			else begin
				res.served_id = slot_keys[0];
				drop_slot(0);
			end
		end
		FN_CANCEL: begin
			if (pos < 0)
				res.status = STAT_MISS;
			else
				drop_slot(pos);
		end
		default: begin
			if (pos < 0)
				res.status = STAT_MISS;
			else
				res.found_age = slot_ages[pos];
		end
		endcase
		res.count = CNT_OUT_W'(held);
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_t want;
		if (!arst_n) begin
			held = 0;
			n_pref = 0;
			pref_age = PREF_AGE_RESET;
			predicted_replies.delete();
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				pref_age = cfg_data;
			if (in_valid && in_ready)
				predicted_replies.push_back(queue_op_result(in_data));
			if (out_valid && out_ready) begin
				if (predicted_replies.size() == 0)
					report($sformatf("result %h arrived with no request waiting", out_data));
				else begin
					want = predicted_replies.pop_front();
					if (out_data.status !== want.status)
						report($sformatf("status got %0d, predicted %0d",
							out_data.status, want.status));
					if (out_data.served_id !== want.served_id)
						report($sformatf("served_id got %h, predicted %h",
							out_data.served_id, want.served_id));
					if (out_data.found_age !== want.found_age)
						report($sformatf("found_age got %0d, predicted %0d",
							out_data.found_age, want.found_age));
					if (out_data.count !== want.count)
						report($sformatf("count got %0d, predicted %0d",
							out_data.count, want.count));
				end
			end
			pending <= predicted_replies.size();
		end
		fails <= mismatch_total;
	end

endmodule

// ===== bench/tb_two_class_priority_queue.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Two-class priority queue testbench
// Drives a short directed sequence and then phases of random requests, each
// phase under a new preferred_age setting and a different mix of operations,
// with bursty requests and a stalling result side. The checker does the
// prediction and comparison; this module makes stimulus and gives the verdict.
// ---------------------------------------------------------------------------
module tb_two_class_priority_queue;
	import tcpq_pkg::*;

	localparam int CAPACITY        = 16;
	localparam int PHASES          = 8;
	localparam int ITEMS_PER_PHASE = 200;
	localparam int POOL_SIZE       = 24;
	localparam int SETTLE_CYCLES   = 8;
	localparam int IDLE_LIMIT      = 2000;

	typedef enum logic [1:0] {
		MIX_FILL,
		MIX_DRAIN,
		MIX_EVEN
	} op_mix_t;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_COIN,
		RX_SPARSE,
		RX_BURSTY
	} rx_mode_t;

	logic             clk;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	in_t              in_data = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	out_t             out_data;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [AGE_W-1:0] cfg_data = PREF_AGE_RESET;
	int               fails;
	int               pending;

	logic [AGE_W-1:0] threshold = PREF_AGE_RESET;
	logic [KEY_W-1:0] key_pool [POOL_SIZE];
	int               burst_left = 0;
	int               idle_cycles = 0;
	rx_mode_t         rx_mode = RX_OPEN;
	int               rx_tick = 0;
	int               rx_hold = 0;

	two_class_priority_queue #(
		.CAPACITY(CAPACITY)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	tcpq_order_checker #(
		.CAPACITY(CAPACITY)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.fails(fails),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// The result side switches at random among open, coin-toss, sparse and bursty stall behavior.
	always @(posedge clk) begin
		rx_tick <= rx_tick + 1;
		if (rx_tick % 256 == 255)
			rx_mode <= rx_mode_t'($urandom_range(0, 3));
		case (rx_mode)
		RX_OPEN: out_ready <= 1'b1;
		RX_COIN: out_ready <= 1'($urandom_range(0, 1));
		RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
		default: begin
			if (rx_hold > 0) begin
				out_ready <= 1'b0;
				rx_hold <= rx_hold - 1;
			end else begin
				out_ready <= 1'b1;
				if ($urandom_range(0, 7) == 0)
					rx_hold <= $urandom_range(4, 30);
			end
		end
		endcase
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
			$display("TEST FAILED");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	// Issues one request, in most cases inserting a random gap when a burst runs out.
	task automatic send_request(input logic [1:0] func, input logic [KEY_W-1:0] id,
			input logic [AGE_W-1:0] age);
		in_t req;
		req.func = func;
		req.id = id;
		req.age = age;
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 12);
		end
		burst_left--;
		in_valid <= 1'b1;
		in_data <= req;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_setting(input logic [AGE_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		threshold = value;
	endtask

	// Most keys come from a small pool so that duplicates, cancels and lookups hit.
	function automatic logic [KEY_W-1:0] pick_key();
		if ($urandom_range(0, 3) != 0)
			return key_pool[$urandom_range(0, POOL_SIZE - 1)];
		return KEY_W'($urandom);
	endfunction

	function automatic logic [AGE_W-1:0] pick_age();
		case ($urandom_range(0, 5))
		0: return '0;
		1: return '1;
		2: return threshold;
		3: return threshold - 1'b1;
		4: return threshold + 1'b1;
		default: return AGE_W'($urandom);
		endcase
	endfunction

	function automatic logic [1:0] pick_func(input op_mix_t mix);
		int r;
		int ins_pct;
		int srv_pct;
		r = $urandom_range(0, 99);
		case (mix)
		MIX_FILL: begin
			ins_pct = 60;
			srv_pct = 72;
		end
		MIX_DRAIN: begin
			ins_pct = 20;
			srv_pct = 60;
		end
		default: begin
			ins_pct = 35;
			srv_pct = 55;
		end
		endcase
		if (r < ins_pct)
			return FN_INSERT;
		if (r < srv_pct)
			return FN_SERVE;
		if (r < 86)
			return FN_CANCEL;
		return FN_LOOKUP;
	endfunction

	initial begin
		int               p;
		int               n;
		logic [AGE_W-1:0] setting;
		logic [KEY_W-1:0] fill_key;
		logic [AGE_W-1:0] fill_age;
		foreach (key_pool[i])
			key_pool[i] = KEY_W'($urandom);
		key_pool[0] = '0;
		key_pool[1] = '1;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Serve, cancel and lookup on an empty queue.
		send_request(FN_SERVE, KEY_W'($urandom), AGE_W'($urandom));
		send_request(FN_CANCEL, 16'h1234, '0);
		send_request(FN_LOOKUP, '0, '1);

		// Fill to capacity with both classes and ages on either side of the threshold.
		for (n = 0; n < CAPACITY; n++) begin
			fill_key = (n == 1) ? 16'hFFFF : KEY_W'(n * 16'h0101);
			case (n)
			0: fill_age = '0;
			1: fill_age = '1;
			2: fill_age = PREF_AGE_RESET;
			3: fill_age = PREF_AGE_RESET - 1'b1;
			default: fill_age = AGE_W'($urandom);
			endcase
			send_request(FN_INSERT, fill_key, fill_age);
		end

		// A new key into a full queue, then a duplicate into a full queue.
		send_request(FN_INSERT, 16'hBEEF, 8'd10);
		send_request(FN_INSERT, 16'hFFFF, '0);
		send_request(FN_LOOKUP, 16'hFFFF, '0);
		send_request(FN_LOOKUP, 16'hBEEF, '0);
		// Cancel a preferred entry from the middle of the preferred class.
		send_request(FN_CANCEL, 16'h0202, '0);
		send_request(FN_SERVE, '0, '0);

		for (p = 0; p < PHASES; p++) begin
			settle();
			case (p)
			0: setting = '0;
			1: setting = '1;
			3: setting = 8'd128;
			5: setting = 8'd1;
			7: setting = 8'd254;
			default: setting = AGE_W'($urandom);
			endcase
			write_setting(setting);
			repeat (ITEMS_PER_PHASE)
				send_request(pick_func(op_mix_t'(p % 3)), pick_key(), pick_age());
		end

		settle();
		if (fails == 0 && pending == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
